@@ rtl/core/wmca_pkg.sv @@
// Shared types, codes and widths for the weighted mean and covariance accumulator.
package wmca_pkg;

    // Default number of vector elements the store is built for.
    localparam int DEF_MAX_DIM = 8;

    // Action codes of an input transaction.
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Status codes of a read result.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NODATA = 2'd1;
    localparam logic [1:0] ST_ONE    = 2'd2;

    // Operand selection of the shared divider.
    localparam logic [1:0] DIV_F    = 2'd0;
    localparam logic [1:0] DIV_MEAN = 2'd1;
    localparam logic [1:0] DIV_COV  = 2'd2;
    localparam logic [1:0] DIV_COVP = 2'd3;

    // Operand selection of the shared multiplier.
    localparam logic [1:0] MUL_DEV = 2'd0;
    localparam logic [1:0] MUL_HI  = 2'd1;
    localparam logic [1:0] MUL_LO  = 2'd2;

    // Divider geometry: 72-bit dividend, 33-bit divisor, one quotient bit a cycle.
    localparam int DIV_NW = 72;
    localparam int DIV_DW = 33;
    localparam int DIV_CW = 7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       clear;
        logic       div_start;
        logic [1:0] div_sel;
        logic       f_wr;
        logic       seed;
        logic       dev_wr;
        logic       mac_rd;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       s_wr;
        logic       s_rd;
        logic       c_inc;
        logic       sum_wr;
        logic       pos_upd;
        logic       mean_wr;
        logic       cov_wr;
        logic       covp_wr;
        logic       out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pos_zero;
        logic w_zero;
        logic w_gt1;
        logic pos_lt_dim;
        logic idx_lt_dim;
        logic idx_lt_tri;
        logic c_last;
        logic div_busy;
        logic div_done;
    } t_sts;

endpackage

@@ rtl/core/wmca_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
module wmca_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [wmca_pkg::DIV_NW-1:0]     i_dividend,
    input  logic [wmca_pkg::DIV_DW-1:0]     i_divisor,
    output logic [wmca_pkg::DIV_NW-1:0]     o_quotient,
    output logic                            o_busy,
    output logic                            o_done
);

    localparam int NW = wmca_pkg::DIV_NW;
    localparam int DW = wmca_pkg::DIV_DW;
    localparam int CW = wmca_pkg::DIV_CW;

    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   sh;
    logic [DW:0]   diff;
    logic          ge;

    // One trial subtraction per cycle.
    assign sh   = {r_rem, r_q[NW-1]};
    assign diff = sh - {1'b0, r_d};
    assign ge   = (sh >= {1'b0, r_d});

    // Control: busy while the quotient bits are produced, then a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    // Shift register holds the dividend and collects the quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_d   <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[NW-2:0], ge};
            r_rem <= ge ? diff[DW-1:0] : sh[DW-1:0];
        end
    end

    assign o_quotient = r_q;
    assign o_busy     = r_busy;
    assign o_done     = r_done;

endmodule

@@ rtl/core/wmca_dp.sv @@
// Datapath: sums, deviations, scatter memory, shared multiplier and divider.
module wmca_dp #(
    parameter int MAX_DIM = wmca_pkg::DEF_MAX_DIM
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [3:0]           i_cfg_wdata,
    input  logic [1:0]           i_action,
    input  logic signed [15:0]   i_value,
    input  logic [7:0]           i_weight,
    input  logic                 i_last_element,
    input  logic [5:0]           i_entry_index,
    input  wmca_pkg::t_cmd       i_cmd,
    output wmca_pkg::t_sts       o_sts,
    output logic signed [31:0]   o_mean_value,
    output logic signed [48:0]   o_cov_value,
    output logic signed [48:0]   o_covp_value,
    output logic [31:0]          o_total_weight,
    output logic [1:0]           o_status
);

    localparam int TRI = MAX_DIM * (MAX_DIM + 1) / 2;
    localparam int PW  = $clog2(MAX_DIM + 1);
    localparam int DIW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int SAW = (TRI > 1) ? $clog2(TRI) : 1;
    localparam int EW  = (PW > 4) ? PW : 4;
    localparam int EM  = 2 * EW;
    localparam int PM  = 2 * PW;
    localparam int NW  = wmca_pkg::DIV_NW;
    localparam int DW  = wmca_pkg::DIV_DW;

    // Saturate a mean quotient to signed Q16.16.
    function automatic logic [31:0] f_mean_sat(input logic [NW-1:0] q, input logic neg);
        logic [31:0] v;
        if (neg) begin
            v = (q > NW'(32'h8000_0000)) ? 32'h8000_0000 : q[31:0];
            return -v;
        end
        v = (q > NW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
        return v;
    endfunction

    // Saturate a covariance quotient to 49 signed bits.
    function automatic logic [48:0] f_cov_sat(input logic [NW-1:0] q, input logic neg);
        logic [48:0] v;
        if (neg) begin
            v = (q > NW'(49'h1_0000_0000_0000)) ? 49'h1_0000_0000_0000 : q[48:0];
            return -v;
        end
        v = (q > NW'(49'h0_FFFF_FFFF_FFFF)) ? 49'h0_FFFF_FFFF_FFFF : q[48:0];
        return v;
    endfunction

    // Configuration and latched transaction payload.
    logic [3:0]          r_dim;
    logic [1:0]          r_act;
    logic signed [15:0]  r_x;
    logic [7:0]          r_w;
    logic                r_last;
    logic [5:0]          r_idx;

    // Accumulator state.
    logic [31:0]         r_wt;
    logic signed [55:0]  r_sum [MAX_DIM];
    logic signed [32:0]  r_dev [MAX_DIM];
    logic [PW-1:0]       r_pos;
    logic [23:0]         r_f;
    logic [DIW-1:0]      r_c;

    // Scatter memory with one valid bit per entry.
    logic signed [63:0]  m_scat [TRI];
    logic [TRI-1:0]      r_sv;
    logic signed [63:0]  r_s_rdata;
    logic                r_s_rvalid;

    // Multiply-accumulate pipeline registers.
    logic signed [32:0]  r_dev_r;
    logic signed [32:0]  r_dev_c;
    logic [63:0]         r_prod;
    logic [47:0]         r_hi;
    logic [47:0]         r_lo;
    logic                r_neg;

    // Staged read result and output register.
    logic [31:0]         r_mean;
    logic [48:0]         r_cov;
    logic [48:0]         r_covp;
    logic [31:0]         r_o_mean;
    logic [48:0]         r_o_cov;
    logic [48:0]         r_o_covp;
    logic [31:0]         r_o_wt;
    logic [1:0]          r_o_status;

    logic [EW-1:0]       eff;
    logic [EM-1:0]       tri_full;
    logic                rd_mode;
    logic [DIW-1:0]      sum_ix;
    logic [DIW-1:0]      pos_ix;
    logic signed [55:0]  sum_rd;
    logic [55:0]         sum_mag;
    logic signed [63:0]  s_val;
    logic [63:0]         s_mag;
    logic [39:0]         wprod;
    logic [NW-1:0]       div_n;
    logic [DW-1:0]       div_d;
    logic [NW-1:0]       div_q;
    logic                div_busy;
    logic                div_done;
    logic [31:0]         mean_q;
    logic signed [32:0]  dev;
    logic signed [24:0]  wx;
    logic signed [56:0]  sum57;
    logic signed [55:0]  sum_sat;
    logic [31:0]         mag_r;
    logic [31:0]         mag_c;
    logic [32:0]         neg_r;
    logic [32:0]         neg_c;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         mul_p;
    logic [56:0]         term_m;
    logic signed [63:0]  term;
    logic signed [64:0]  s65;
    logic signed [63:0]  s_new;
    logic [SAW-1:0]      mac_addr;
    logic [SAW-1:0]      s_addr;
    logic [32:0]         w33;

    // Effective dimension and the size of its triangle.
    assign eff      = (EW'(r_dim) > EW'(MAX_DIM)) ? EW'(MAX_DIM) : EW'(r_dim);
    assign tri_full = (EM'(eff) * (EM'(eff) + EM'(1))) >> 1;

    // Weighted sum selected by the current element or the read index.
    assign rd_mode = (r_act == wmca_pkg::ACT_READ);
    assign pos_ix  = r_pos[DIW-1:0];
    assign sum_ix  = rd_mode ? r_idx[DIW-1:0] : pos_ix;
    assign sum_rd  = r_sum[sum_ix];
    assign sum_mag = sum_rd[55] ? 56'(-sum_rd) : 56'(sum_rd);
    assign s_val   = r_s_rvalid ? r_s_rdata : 64'sd0;
    assign s_mag   = s_val[63] ? 64'(-s_val) : 64'(s_val);
    assign wprod   = 40'(r_wt) * 40'(r_w);

    // Divider operand selection.
    always_comb begin
        unique case (i_cmd.div_sel)
            wmca_pkg::DIV_F: begin
                div_n = {16'b0, wprod, 16'b0};
                div_d = DW'(r_wt) + DW'(r_w);
            end
            wmca_pkg::DIV_MEAN: begin
                div_n = {sum_mag, 16'b0};
                div_d = DW'(r_wt);
            end
            wmca_pkg::DIV_COV: begin
                div_n = NW'(s_mag);
                div_d = DW'(r_wt);
            end
            default: begin
                div_n = NW'(s_mag);
                div_d = DW'(r_wt) - DW'(1);
            end
        endcase
    end

    wmca_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_quotient (div_q),
        .o_busy     (div_busy),
        .o_done     (div_done)
    );

    // Deviation of the new element from the old mean, and its weighted value.
    assign mean_q = f_mean_sat(div_q, sum_rd[55]);
    assign dev    = {r_x[15], r_x, 16'b0} - {mean_q[31], mean_q};
    assign wx     = $signed({17'b0, r_w}) * $signed({{9{r_x[15]}}, r_x});

    // Saturating update of the weighted sum.
    assign sum57   = {sum_rd[55], sum_rd} + {{32{wx[24]}}, wx};
    assign sum_sat = (sum57[56] != sum57[55]) ?
                     (sum57[56] ? {1'b1, 55'b0} : {1'b0, {55{1'b1}}}) : sum57[55:0];

    // Shared multiplier for the deviation product and both factor products.
    assign neg_r = -r_dev_r;
    assign neg_c = -r_dev_c;
    assign mag_r = r_dev_r[32] ? neg_r[31:0] : r_dev_r[31:0];
    assign mag_c = r_dev_c[32] ? neg_c[31:0] : r_dev_c[31:0];

    always_comb begin
        unique case (i_cmd.mul_sel)
            wmca_pkg::MUL_DEV: begin
                mul_a = mag_r;
                mul_b = mag_c;
            end
            wmca_pkg::MUL_HI: begin
                mul_a = {8'b0, r_prod[63:40]};
                mul_b = {8'b0, r_f};
            end
            default: begin
                mul_a = {8'b0, r_prod[39:16]};
                mul_b = {8'b0, r_f};
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Scatter term and saturating add into the stored entry.
    assign term_m = {1'b0, r_hi, 8'b0} + {25'b0, r_lo[47:16]};
    assign term   = r_neg ? -$signed(64'(term_m)) : $signed(64'(term_m));
    assign s65    = {s_val[63], s_val} + {term[63], term};
    assign s_new  = (s65[64] != s65[63]) ?
                    (s65[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}}) : s65[63:0];

    // Scatter addressing: row base plus column for updates, index for reads.
    assign mac_addr = SAW'((PM'(r_pos) * (PM'(r_pos) + PM'(1))) >> 1) + SAW'(r_c);
    assign s_addr   = rd_mode ? SAW'(r_idx) : mac_addr;

    assign w33 = {1'b0, r_wt} + 33'(r_w);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= 4'd8;
        end else if (i_cfg_we) begin
            r_dim <= i_cfg_wdata;
        end
    end

    // Transaction payload capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act  <= i_action;
            r_x    <= i_value;
            r_w    <= i_weight;
            r_last <= i_last_element;
            r_idx  <= i_entry_index;
        end
    end

    // Total weight, element position and update factor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_wt  <= '0;
            r_pos <= '0;
            r_f   <= '0;
        end else begin
            if (i_cmd.f_wr) begin
                r_f <= div_q[23:0];
            end
            if (i_cmd.pos_upd) begin
                if (r_last) begin
                    r_wt  <= w33[32] ? 32'hFFFF_FFFF : w33[31:0];
                    r_pos <= '0;
                end else if (r_pos < PW'(MAX_DIM)) begin
                    r_pos <= r_pos + PW'(1);
                end
            end
        end
    end

    // Weighted sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < MAX_DIM; i++) begin
                r_sum[i] <= '0;
            end
        end else if (i_cmd.seed) begin
            r_sum[pos_ix] <= 56'(wx);
        end else if (i_cmd.sum_wr) begin
            r_sum[pos_ix] <= sum_sat;
        end
    end

    // Deviations of the current sample and the column counter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.dev_wr) begin
            r_dev[pos_ix] <= dev;
            r_dev_r       <= dev;
            r_c           <= '0;
        end else if (i_cmd.c_inc) begin
            r_c <= r_c + DIW'(1);
        end
        if (i_cmd.mac_rd) begin
            r_dev_c <= r_dev[r_c];
        end
    end

    // Multiplier result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            unique case (i_cmd.mul_sel)
                wmca_pkg::MUL_DEV: begin
                    r_prod <= mul_p;
                    r_neg  <= r_dev_r[32] ^ r_dev_c[32];
                end
                wmca_pkg::MUL_HI: r_hi <= mul_p[47:0];
                default:          r_lo <= mul_p[47:0];
            endcase
        end
    end

    // Scatter memory array with registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.s_wr) begin
            m_scat[s_addr] <= s_new;
        end
        if (i_cmd.s_rd) begin
            r_s_rdata <= m_scat[s_addr];
        end
    end

    // Valid bits make a cleared entry read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear || i_cmd.seed) begin
            r_sv <= '0;
        end else if (i_cmd.s_wr) begin
            r_sv[s_addr] <= 1'b1;
        end
        if (i_cmd.s_rd) begin
            r_s_rvalid <= r_sv[s_addr];
        end
    end

    // Staged read result, zero unless computed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mean <= '0;
            r_cov  <= '0;
            r_covp <= '0;
        end else begin
            if (i_cmd.mean_wr) r_mean <= mean_q;
            if (i_cmd.cov_wr)  r_cov  <= f_cov_sat(div_q, s_val[63]);
            if (i_cmd.covp_wr) r_covp <= f_cov_sat(div_q, s_val[63]);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_mean <= r_mean;
            r_o_cov  <= r_cov;
            r_o_covp <= r_covp;
            r_o_wt   <= r_wt;
            if (r_wt == '0) begin
                r_o_status <= wmca_pkg::ST_NODATA;
            end else if (r_wt > 32'd1) begin
                r_o_status <= wmca_pkg::ST_OK;
            end else begin
                r_o_status <= wmca_pkg::ST_ONE;
            end
        end
    end

    assign o_mean_value   = r_o_mean;
    assign o_cov_value    = r_o_cov;
    assign o_covp_value   = r_o_covp;
    assign o_total_weight = r_o_wt;
    assign o_status       = r_o_status;

    // Status toward the controller.
    assign o_sts.pos_zero   = (r_pos == '0);
    assign o_sts.w_zero     = (r_wt == '0);
    assign o_sts.w_gt1      = (r_wt > 32'd1);
    assign o_sts.pos_lt_dim = (EW'(r_pos) < eff);
    assign o_sts.idx_lt_dim = (EM'(r_idx) < EM'(eff));
    assign o_sts.idx_lt_tri = (EM'(r_idx) < tri_full);
    assign o_sts.c_last     = (PW'(r_c) == r_pos);
    assign o_sts.div_busy   = div_busy;
    assign o_sts.div_done   = div_done;

endmodule

@@ rtl/core/wmca_ctrl.sv @@
// Controller state machine that sequences add, read and clear transactions.
module wmca_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_action,
    input  logic            i_out_stall,
    input  wmca_pkg::t_sts  i_sts,
    output wmca_pkg::t_cmd  o_cmd,
    output logic            o_in_stall,
    output logic            o_out_valid
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_ADD_F   = 5'd1;
    localparam logic [4:0] S_ADD_FW  = 5'd2;
    localparam logic [4:0] S_ADD_CHK = 5'd3;
    localparam logic [4:0] S_ADD_MW  = 5'd4;
    localparam logic [4:0] S_MAC_RD  = 5'd5;
    localparam logic [4:0] S_MAC_M1  = 5'd6;
    localparam logic [4:0] S_MAC_M2  = 5'd7;
    localparam logic [4:0] S_MAC_M3  = 5'd8;
    localparam logic [4:0] S_MAC_WR  = 5'd9;
    localparam logic [4:0] S_ADD_SUM = 5'd10;
    localparam logic [4:0] S_ADD_END = 5'd11;
    localparam logic [4:0] S_RD_MEAN = 5'd12;
    localparam logic [4:0] S_RD_MW   = 5'd13;
    localparam logic [4:0] S_RD_COV  = 5'd14;
    localparam logic [4:0] S_RD_CS   = 5'd15;
    localparam logic [4:0] S_RD_CW   = 5'd16;
    localparam logic [4:0] S_RD_P    = 5'd17;
    localparam logic [4:0] S_RD_PW   = 5'd18;
    localparam logic [4:0] S_RD_OUT  = 5'd19;

    logic [4:0]     r_state;
    logic [4:0]     n_state;
    logic           r_out_valid;
    logic           n_out_valid;
    logic           accept;
    wmca_pkg::t_cmd cmd;

    assign accept = i_in_valid && (r_state == S_IDLE);

    // Next state and command decode.
    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    if (i_action == wmca_pkg::ACT_ADD) begin
                        n_state = S_ADD_F;
                    end else if (i_action == wmca_pkg::ACT_READ) begin
                        n_state = S_RD_MEAN;
                    end else if (i_action == wmca_pkg::ACT_CLEAR) begin
                        cmd.clear = 1'b1;
                    end
                end
            end
            S_ADD_F: begin
                if (i_sts.pos_zero && !i_sts.w_zero) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = wmca_pkg::DIV_F;
                    n_state       = S_ADD_FW;
                end else begin
                    n_state = S_ADD_CHK;
                end
            end
            S_ADD_FW: begin
                if (i_sts.div_done) begin
                    cmd.f_wr = 1'b1;
                    n_state  = S_ADD_CHK;
                end
            end
            S_ADD_CHK: begin
                if (!i_sts.pos_lt_dim) begin
                    n_state = S_ADD_END;
                end else if (i_sts.w_zero) begin
                    cmd.seed = 1'b1;
                    n_state  = S_ADD_END;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = wmca_pkg::DIV_MEAN;
                    n_state       = S_ADD_MW;
                end
            end
            S_ADD_MW: begin
                cmd.div_sel = wmca_pkg::DIV_MEAN;
                if (i_sts.div_done) begin
                    cmd.dev_wr = 1'b1;
                    n_state    = S_MAC_RD;
                end
            end
            S_MAC_RD: begin
                cmd.mac_rd = 1'b1;
                cmd.s_rd   = 1'b1;
                n_state    = S_MAC_M1;
            end
            S_MAC_M1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = wmca_pkg::MUL_DEV;
                n_state     = S_MAC_M2;
            end
            S_MAC_M2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = wmca_pkg::MUL_HI;
                n_state     = S_MAC_M3;
            end
            S_MAC_M3: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = wmca_pkg::MUL_LO;
                n_state     = S_MAC_WR;
            end
            S_MAC_WR: begin
                cmd.s_wr = 1'b1;
                if (i_sts.c_last) begin
                    n_state = S_ADD_SUM;
                end else begin
                    cmd.c_inc = 1'b1;
                    n_state   = S_MAC_RD;
                end
            end
            S_ADD_SUM: begin
                cmd.sum_wr = 1'b1;
                n_state    = S_ADD_END;
            end
            S_ADD_END: begin
                cmd.pos_upd = 1'b1;
                n_state     = S_IDLE;
            end
            S_RD_MEAN: begin
                if (i_sts.w_zero) begin
                    n_state = S_RD_OUT;
                end else if (i_sts.idx_lt_dim) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = wmca_pkg::DIV_MEAN;
                    n_state       = S_RD_MW;
                end else begin
                    n_state = S_RD_COV;
                end
            end
            S_RD_MW: begin
                cmd.div_sel = wmca_pkg::DIV_MEAN;
                if (i_sts.div_done) begin
                    cmd.mean_wr = 1'b1;
                    n_state     = S_RD_COV;
                end
            end
            S_RD_COV: begin
                if (i_sts.idx_lt_tri) begin
                    cmd.s_rd = 1'b1;
                    n_state  = S_RD_CS;
                end else begin
                    n_state = S_RD_OUT;
                end
            end
            S_RD_CS: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = wmca_pkg::DIV_COV;
                n_state       = S_RD_CW;
            end
            S_RD_CW: begin
                if (i_sts.div_done) begin
                    cmd.cov_wr = 1'b1;
                    n_state    = S_RD_P;
                end
            end
            S_RD_P: begin
                if (i_sts.w_gt1) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = wmca_pkg::DIV_COVP;
                    n_state       = S_RD_PW;
                end else begin
                    n_state = S_RD_OUT;
                end
            end
            S_RD_PW: begin
                if (i_sts.div_done) begin
                    cmd.covp_wr = 1'b1;
                    n_state     = S_RD_OUT;
                end
            end
            S_RD_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid follows loads and downstream acceptance.
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // The divider is never restarted while a division is running.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !i_sts.div_busy)
        else $error("divider started while busy");

    // Scatter updates happen only for an element in range with weight present.
    a_mac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.s_wr |-> (i_sts.pos_lt_dim && !i_sts.w_zero))
        else $error("scatter written outside an accumulating element");

    // Seeding happens only with no accumulated weight.
    a_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.seed |-> (i_sts.w_zero && i_sts.pos_lt_dim))
        else $error("seed issued with weight present");

endmodule

@@ rtl/core/weighted_mean_covariance_accumulator_unit.sv @@
// Weighted mean and covariance accumulator: one transaction at a time. An add
// transaction runs the update-factor divide for the first element of a sample
// when weight is present. An element in range with weight present then runs the
// mean divide and one scatter update per entry of its row (row r has r+1
// entries). A read runs up to three divides (mean, covariance, corrected
// covariance), and its result may wait for the output register to free up. A
// clear is done in the cycle in which it is accepted. The work is serialised by
// the shared divider, which yields one quotient bit per cycle, and by the single
// shared multiplier in the scatter update loop. Results wait in an output
// register, so a new transaction is taken while a read result is still held.
module weighted_mean_covariance_accumulator_unit #(
    parameter int MAX_DIM = wmca_pkg::DEF_MAX_DIM
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_action,
    input  logic signed [15:0]  i_value,
    input  logic [7:0]          i_weight,
    input  logic                i_last_element,
    input  logic [5:0]          i_entry_index,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [31:0]  o_mean_value,
    output logic signed [48:0]  o_cov_value,
    output logic signed [48:0]  o_covp_value,
    output logic [31:0]         o_total_weight,
    output logic [1:0]          o_status
);

    wmca_pkg::t_cmd cmd;
    wmca_pkg::t_sts sts;

    // Sequencer.
    wmca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Arithmetic and storage.
    wmca_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_action       (i_action),
        .i_value        (i_value),
        .i_weight       (i_weight),
        .i_last_element (i_last_element),
        .i_entry_index  (i_entry_index),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_mean_value   (o_mean_value),
        .o_cov_value    (o_cov_value),
        .o_covp_value   (o_covp_value),
        .o_total_weight (o_total_weight),
        .o_status       (o_status)
    );

endmodule

@@ verif/weighted_mean_covariance_accumulator_unit_tb.sv @@
// Self-checking testbench for the weighted mean and covariance accumulator unit.
`timescale 1ns / 1ps

// Predicts read results from accepted transactions and checks the block's results.
class t_covariance_scoreboard;
    typedef struct {
        logic [31:0] mean;
        logic [48:0] cov;
        logic [48:0] covp;
        logic [31:0] weight;
        logic [1:0]  status;
    } t_read_result;

    int unsigned  dim_reg;
    int unsigned  weight_sum;
    longint       elem_sums[8];
    longint       elem_devs[8];
    longint       scatter[36];
    int unsigned  elem_pos;
    longint unsigned factor;
    t_read_result pending_reads[$];
    int           errors;

    function new();
        dim_reg = 8;
        errors  = 0;
        clear_stats();
    endfunction

    function void clear_stats();
        weight_sum = 0;
        foreach (elem_sums[i]) elem_sums[i] = 0;
        foreach (elem_devs[i]) elem_devs[i] = 0;
        foreach (scatter[i]) scatter[i] = 0;
        elem_pos = 0;
        factor   = 0;
    endfunction

    function int unsigned dim_in_use();
        return (dim_reg > 8) ? 8 : dim_reg;
    endfunction

    function int pending();
        return pending_reads.size();
    endfunction

    function longint unsigned magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Sum over weight in Q16.16, truncated toward zero and saturated to 32 bits.
    function longint mean_q16(longint t, int unsigned w);
        longint unsigned m, q, r, v;
        m = magnitude(t);
        q = m / w;
        r = m % w;
        if (q > 65536) q = 65536;
        v = (q << 16) + ((r << 16) / w);
        if (t < 0) begin
            if (v > 64'h8000_0000) v = 64'h8000_0000;
            return -longint'(v);
        end
        if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
        return longint'(v);
    endfunction

    // Signed divide truncated toward zero, saturated to 49 bits.
    function longint div_sat49(longint s, longint unsigned d);
        longint unsigned q, lim;
        q   = magnitude(s) / d;
        lim = (64'd1 << 48) - ((s < 0) ? 0 : 1);
        if (q > lim) q = lim;
        return (s < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint sat_add(longint a, longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        return s;
    endfunction

    function longint scatter_term(longint dr, longint dc, longint unsigned f);
        longint unsigned p, ph, pl, m;
        p  = (magnitude(dr) * magnitude(dc)) >> 16;
        ph = p >> 24;
        pl = p & 64'hFF_FFFF;
        m  = ((ph * f) << 8) + ((pl * f) >> 16);
        return ((dr < 0) != (dc < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function void add_element(int x, int unsigned w, bit last);
        int unsigned     r, base;
        longint          wx, s;
        longint unsigned t;
        r = elem_pos;
        if (r == 0 && weight_sum != 0)
            factor = ((longint'(weight_sum) * w) << 16) / (longint'(weight_sum) + w);
        if (r < dim_in_use()) begin
            wx = longint'(w) * longint'(x);
            if (weight_sum == 0) begin
                elem_sums[r] = wx;
                foreach (scatter[i]) scatter[i] = 0;
            end else begin
                base = r * (r + 1) / 2;
                elem_devs[r] = longint'(x) * 65536 - mean_q16(elem_sums[r], weight_sum);
                for (int c = 0; c <= r; c++)
                    scatter[base + c] = sat_add(scatter[base + c],
                        scatter_term(elem_devs[r], elem_devs[c], factor));
                s = elem_sums[r] + wx;
                if (s > ((64'sd1 <<< 55) - 1)) s = (64'sd1 <<< 55) - 1;
                if (s < -(64'sd1 <<< 55)) s = -(64'sd1 <<< 55);
                elem_sums[r] = s;
            end
        end
        if (last) begin
            t = longint'(weight_sum) + w;
            weight_sum = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
            elem_pos = 0;
        end else if (elem_pos < 8) begin
            elem_pos++;
        end
    endfunction

    // Updates the statistics for one accepted input transaction.
    function void note_transaction(logic [1:0] action, logic signed [15:0] value,
                                   logic [7:0] weight, logic last, logic [5:0] idx);
        t_read_result res;
        int unsigned  dim, tri_size;
        longint       mean, cov, covp;
        unique case (action)
            wmca_pkg::ACT_ADD: begin
                add_element(int'(value), weight, last);
            end
            wmca_pkg::ACT_CLEAR: begin
                clear_stats();
            end
            wmca_pkg::ACT_READ: begin
                dim      = dim_in_use();
                tri_size = dim * (dim + 1) / 2;
                mean     = 0;
                cov      = 0;
                covp     = 0;
                if (weight_sum == 0) begin
                    res.status = wmca_pkg::ST_NODATA;
                end else begin
                    if (idx < dim) mean = mean_q16(elem_sums[idx], weight_sum);
                    if (idx < tri_size) begin
                        cov = div_sat49(scatter[idx], weight_sum);
                        if (weight_sum > 1)
                            covp = div_sat49(scatter[idx], longint'(weight_sum) - 1);
                    end
                    res.status = (weight_sum > 1) ? wmca_pkg::ST_OK : wmca_pkg::ST_ONE;
                end
                res.mean   = mean[31:0];
                res.cov    = cov[48:0];
                res.covp   = covp[48:0];
                res.weight = weight_sum;
                pending_reads.push_back(res);
            end
            default: begin
                // Unknown actions are dropped by the block.
            end
        endcase
    endfunction

    // Compares one accepted result with the oldest outstanding read.
    function void check_result(logic [31:0] mean, logic [48:0] cov, logic [48:0] covp,
                               logic [31:0] weight, logic [1:0] status);
        t_read_result e;
        if (pending_reads.size() == 0) begin
            $error("unexpected result transaction: mean %h status %h", mean, status);
            errors++;
            return;
        end
        e = pending_reads.pop_front();
        if (mean !== e.mean) begin
            $error("mean_value: expected %h, actual %h", e.mean, mean);
            errors++;
        end
        if (cov !== e.cov) begin
            $error("cov_value: expected %h, actual %h", e.cov, cov);
            errors++;
        end
        if (covp !== e.covp) begin
            $error("covp_value: expected %h, actual %h", e.covp, covp);
            errors++;
        end
        if (weight !== e.weight) begin
            $error("total_weight: expected %h, actual %h", e.weight, weight);
            errors++;
        end
        if (status !== e.status) begin
            $error("status: expected %h, actual %h", e.status, status);
            errors++;
        end
    endfunction
endclass

module weighted_mean_covariance_accumulator_unit_tb;

    localparam logic [1:0] ACT_UNKNOWN = 2'd3;
    localparam int         CYCLE_LIMIT = 2000000;
    localparam int         SETTLE      = 300;
    localparam int         ITEM_TARGET = 450;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [3:0]         i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_action;
    logic signed [15:0] i_value;
    logic [7:0]         i_weight;
    logic               i_last_element;
    logic [5:0]         i_entry_index;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_mean_value;
    logic signed [48:0] o_cov_value;
    logic signed [48:0] o_covp_value;
    logic [31:0]        o_total_weight;
    logic [1:0]         o_status;

    t_covariance_scoreboard sb;
    int  items_sent;
    int  cycles;
    bit  no_idle;

    weighted_mean_covariance_accumulator_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_value        (i_value),
        .i_weight       (i_weight),
        .i_last_element (i_last_element),
        .i_entry_index  (i_entry_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_mean_value   (o_mean_value),
        .o_cov_value    (o_cov_value),
        .o_covp_value   (o_covp_value),
        .o_total_weight (o_total_weight),
        .o_status       (o_status)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on total run length.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** weighted_mean_covariance_accumulator_unit: FAILED **");
            $finish;
        end
    end

    // Result side: random stall before each result, then check it on acceptance.
    initial begin
        int k;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            k = no_idle ? 0 : $urandom_range(0, 10);
            i_out_stall = (k != 0);
            repeat (k) @(negedge i_clk);
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result(o_mean_value, o_cov_value, o_covp_value,
                            o_total_weight, o_status);
        end
    end

    // Sends one input transaction after a random gap; returns at a falling edge.
    task automatic send(logic [1:0] action, logic [15:0] value, logic [7:0] weight,
                        logic last, logic [5:0] idx);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action       = action;
        i_value        = value;
        i_weight       = weight;
        i_last_element = last;
        i_entry_index  = idx;
        i_in_valid     = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_transaction(action, value, weight, last, idx);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Holds off input until every outstanding read has returned and work has settled.
    task automatic drain();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_dim(logic [3:0] d);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = d;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.dim_reg  = d;
    endtask

    function automatic logic [15:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h8000;
        if (r == 1) return 16'h7FFF;
        if (r == 2) return 16'h0000;
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [7:0] pick_weight();
        int r;
        r = $urandom_range(0, 11);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd1;
        if (r == 2) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_read();
        int unsigned dim, tri_size;
        logic [5:0]  idx;
        dim      = sb.dim_in_use();
        tri_size = dim * (dim + 1) / 2;
        if ($urandom_range(0, 99) < 85 && tri_size > 0) idx = 6'($urandom_range(0, tri_size - 1));
        else idx = 6'($urandom_range(0, 63));
        send(wmca_pkg::ACT_READ, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)), idx);
    endtask

    // One sample of n elements; mixed gives each element its own weight.
    task automatic send_sample(int n, bit mixed);
        logic [7:0] w;
        w = pick_weight();
        for (int i = 0; i < n; i++) begin
            if (mixed) w = pick_weight();
            send(wmca_pkg::ACT_ADD, pick_value(), w, i == n - 1, 6'($urandom_range(0, 63)));
        end
    endtask

    // Random traffic, mostly complete samples, some of them followed by a read.
    task automatic run_random(int until_items);
        int k, n;
        while (items_sent < until_items) begin
            n = sb.dim_in_use();
            if (n == 0) n = 1;
            k = $urandom_range(0, 99);
            if (k < 70) begin
                send_sample(n, 1'b0);
                if ($urandom_range(0, 2) == 0) send_read();
            end else if (k < 82) begin
                send_read();
            end else if (k < 86) begin
                send_sample($urandom_range(1, n), 1'b0);
            end else if (k < 89) begin
                send_sample(n + $urandom_range(1, 3), 1'b0);
            end else if (k < 93) begin
                send_sample(n, 1'b1);
            end else if (k < 95) begin
                send(ACT_UNKNOWN, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
            end else if (k < 97) begin
                send(wmca_pkg::ACT_CLEAR, 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     6'($urandom_range(0, 63)));
            end else begin
                no_idle = ~no_idle;
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        sb             = new();
        items_sent     = 0;
        no_idle        = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = 4'd0;
        i_in_valid     = 1'b0;
        i_action       = wmca_pkg::ACT_ADD;
        i_value        = 16'd0;
        i_weight       = 8'd0;
        i_last_element = 1'b0;
        i_entry_index  = 6'd0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: small dimension, extremes and the special cases.
        write_dim(4'd2);
        send(wmca_pkg::ACT_READ, 16'h0, 8'h0, 1'b0, 6'd0);            // no data yet
        send(wmca_pkg::ACT_ADD, 16'h7FFF, 8'd1, 1'b0, 6'd0);
        send(wmca_pkg::ACT_ADD, 16'h8000, 8'd1, 1'b1, 6'd0);
        send(wmca_pkg::ACT_READ, 16'h0, 8'h0, 1'b0, 6'd0);            // total weight of one
        send(wmca_pkg::ACT_ADD, 16'h8000, 8'd255, 1'b0, 6'd63);
        send(wmca_pkg::ACT_ADD, 16'h7FFF, 8'd255, 1'b1, 6'd63);
        send(wmca_pkg::ACT_READ, 16'hFFFF, 8'hFF, 1'b1, 6'd2);
        send(wmca_pkg::ACT_READ, 16'h0, 8'h0, 1'b0, 6'd1);
        send(wmca_pkg::ACT_READ, 16'h0, 8'h0, 1'b0, 6'd5);            // beyond triangle
        send(wmca_pkg::ACT_READ, 16'h0, 8'h0, 1'b0, 6'd63);
        send(ACT_UNKNOWN, 16'hFFFF, 8'hFF, 1'b1, 6'd63);
        send(wmca_pkg::ACT_ADD, 16'h1234, 8'd7, 1'b1, 6'd0);          // short sample
        send_sample(4, 1'b0);                                         // too many elements
        send(wmca_pkg::ACT_ADD, 16'h7FFF, 8'd0, 1'b0, 6'd0);          // zero weight later
        send(wmca_pkg::ACT_ADD, 16'h8000, 8'd0, 1'b1, 6'd0);
        send(wmca_pkg::ACT_ADD, 16'h0100, 8'd3, 1'b0, 6'd0);          // mixed weights
        send(wmca_pkg::ACT_ADD, 16'hFF00, 8'd200, 1'b1, 6'd0);
        send(wmca_pkg::ACT_READ, 16'h0, 8'h0, 1'b0, 6'd2);
        send(wmca_pkg::ACT_CLEAR, 16'h0, 8'h0, 1'b0, 6'd0);
        send(wmca_pkg::ACT_ADD, 16'h4000, 8'd0, 1'b1, 6'd0);          // zero weight first
        send(wmca_pkg::ACT_READ, 16'h0, 8'h0, 1'b0, 6'd0);

        // Dimension zero: weights still accumulate.
        write_dim(4'd0);
        send(wmca_pkg::ACT_ADD, 16'h5555, 8'd9, 1'b1, 6'd0);
        send(wmca_pkg::ACT_READ, 16'h0, 8'h0, 1'b0, 6'd0);

        // Random phases over several settings.
        write_dim(4'd8);
        send(wmca_pkg::ACT_CLEAR, 16'h0, 8'h0, 1'b0, 6'd0);
        run_random(120);
        drain();                                            // sender waits for all results
        run_random(170);
        write_dim(4'd1);
        send(wmca_pkg::ACT_CLEAR, 16'h0, 8'h0, 1'b0, 6'd0);
        run_random(240);
        write_dim(4'd15);                                   // acts as the maximum
        run_random(320);
        write_dim(4'($urandom_range(2, 7)));
        send(wmca_pkg::ACT_CLEAR, 16'h0, 8'h0, 1'b0, 6'd0);
        run_random(390);
        write_dim(4'd3);
        run_random(ITEM_TARGET);

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** weighted_mean_covariance_accumulator_unit: PASSED **");
        end else begin
            $display("** weighted_mean_covariance_accumulator_unit: FAILED **");
        end
        $finish;
    end
endmodule
